// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16/UTF-32 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int UNIT_W = 21;

    // Depth of the result queue and the width of its pointers and fill level.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_LVL_W = $clog2(RES_DEPTH + 1);

    // Sequence lengths as held in the decoder state.
    localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN_2    = 3'd2;
    localparam logic [2:0] SEQ_LEN_3    = 3'd3;
    localparam logic [2:0] SEQ_LEN_4    = 3'd4;

    localparam logic [UNIT_W-1:0] MAX_CP       = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [UNIT_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 21'h00D800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 21'h00DC00;
    localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [UNIT_W-1:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [UNIT_W-1:0] MIN_CP_2     = 21'h000080;
    localparam logic [UNIT_W-1:0] MIN_CP_3     = 21'h000800;
    localparam logic [UNIT_W-1:0] MIN_CP_4     = 21'h010000;

    typedef struct packed {
        logic [UNIT_W-1:0] acc;
        logic [1:0]        remain;
        logic [2:0]        seq_len;
        logic              failed;
    } dec_state_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              error;
        logic              last;
    } result_t;

    // Results caused by one byte: a count of zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    typedef struct packed {
        logic [RES_LVL_W-1:0] level;
        logic                 has_room;
    } res_status_t;

endpackage

// ===== rtl/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Validating UTF-8 decoder with UTF-16 or UTF-32 output.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per clock cycle, with tlast on the final
// byte of a string, and returns code units with tlast on the last unit that a
// byte causes and tuser set on an error result. A byte is held in an input
// register, decoded in the next cycle and written into a four-entry result
// queue when the queue has room, and its results are shown on the output
// from the queue's entry registers. Every code point gives one result,
// except a supplementary code point in UTF-16 mode, which gives a surrogate
// pair whose two units leave the queue one after the other. The pair comes
// from four bytes, so the sustained byte rate is one per cycle as long as
// the output side takes one result per cycle. The input stalls while the
// queue holds more than two results. After an error the rest of the
// string is dropped without results. The mode register must only be written
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // utf16_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] byte_value
    input  logic        s_axis_tlast,    // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [20:0] code_unit, [23:21] zero
    output logic        m_axis_tuser,    // error
    output logic        m_axis_tlast     // last_unit
);
    import u8u16_pkg::*;

    logic        mode_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eos_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_out_t    dec_res;
    dec_out_t    push;
    result_t     head;
    res_status_t q_status;
    logic        advance;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && q_status.has_room;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    u8u16_dec u_dec (
        .state_cur  (state_reg),
        .byte_in    (in_byte_reg),
        .eos        (in_eos_reg),
        .mode_utf16 (mode_reg),
        .state_nxt  (state_next),
        .dec_out    (dec_res)
    );

    always_comb
    begin
        push = dec_res;
        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

    u8u16_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tready),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .status     (q_status)
    );

    assign m_axis_tdata = {3'b000, head.unit};
    assign m_axis_tuser = head.error;
    assign m_axis_tlast = head.last;

    // The queue never holds more results than it has entries.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= RES_LVL_W'(RES_DEPTH))
        else $error("result queue overfilled");

    // A failed string leaves no partial sequence behind.
    a_failed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.failed |-> (state_reg.remain == 2'd0))
        else $error("partial sequence kept after an error");

    // An error result carries a zero code unit and ends its byte's results.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 24'd0)))
        else $error("malformed error result");

    // The only result that is not the last of its byte is a high surrogate.
    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (!m_axis_tuser && (m_axis_tdata[23:10] == 14'h0036)))
        else $error("first unit of a pair is not a high surrogate");

endmodule

// ===== rtl/u8u16_dec.sv =====
// ----------------------------------------------------------------------------
// u8u16_dec
// Combinational decode of one byte: next sequence state and its results.
// ----------------------------------------------------------------------------
module u8u16_dec (
    input  u8u16_pkg::dec_state_t state_cur,
    input  logic [7:0]            byte_in,
    input  logic                  eos,
    input  logic                  mode_utf16,
    output u8u16_pkg::dec_state_t state_nxt,
    output u8u16_pkg::dec_out_t   dec_out
);
    import u8u16_pkg::*;

    logic [UNIT_W-1:0] acc_shift;
    logic [1:0]        remain_dec;
    logic              overlong;
    logic              bad_value;
    logic              do_error;
    logic              do_emit;
    logic [UNIT_W-1:0] emit_cp;
    logic [UNIT_W-1:0] supp_off;

    assign acc_shift  = {state_cur.acc[UNIT_W-7:0], byte_in[5:0]};
    assign remain_dec = state_cur.remain - 2'd1;
    assign supp_off   = emit_cp - SUPP_BASE;

    always_comb
    begin
        overlong = ((state_cur.seq_len == SEQ_LEN_2) && (acc_shift < MIN_CP_2)) ||
                   ((state_cur.seq_len == SEQ_LEN_3) && (acc_shift < MIN_CP_3)) ||
                   ((state_cur.seq_len == SEQ_LEN_4) && (acc_shift < MIN_CP_4));
        bad_value = overlong || (acc_shift > MAX_CP) ||
                    ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));
    end

    always_comb
    begin
        state_nxt = state_cur;
        do_error  = 1'b0;
        do_emit   = 1'b0;
        emit_cp   = '0;

        if (state_cur.failed)
        begin
            // Skip the rest of a failed string; its final byte rearms the decoder.
            if (eos)
            begin
                state_nxt = '0;
            end
        end
        else if (state_cur.remain == 2'd0)
        begin
            if (byte_in[7] == 1'b0)
            begin
                do_emit = 1'b1;
                emit_cp = {{(UNIT_W-8){1'b0}}, byte_in};
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                state_nxt.acc     = {{(UNIT_W-5){1'b0}}, byte_in[4:0]};
                state_nxt.seq_len = SEQ_LEN_2;
                state_nxt.remain  = 2'd1;
                do_error          = eos;
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                state_nxt.acc     = {{(UNIT_W-4){1'b0}}, byte_in[3:0]};
                state_nxt.seq_len = SEQ_LEN_3;
                state_nxt.remain  = 2'd2;
                do_error          = eos;
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                state_nxt.acc     = {{(UNIT_W-3){1'b0}}, byte_in[2:0]};
                state_nxt.seq_len = SEQ_LEN_4;
                state_nxt.remain  = 2'd3;
                do_error          = eos;
            end
            else
            begin
                do_error = 1'b1;
            end
        end
        else if (byte_in[7:6] != 2'b10)
        begin
            do_error = 1'b1;
        end
        else if (remain_dec != 2'd0)
        begin
            state_nxt.acc    = acc_shift;
            state_nxt.remain = remain_dec;
            do_error         = eos;
        end
        else if (bad_value)
        begin
            do_error = 1'b1;
        end
        else
        begin
            state_nxt = '0;
            do_emit   = 1'b1;
            emit_cp   = acc_shift;
        end

        if (do_error)
        begin
            state_nxt        = '0;
            state_nxt.failed = !eos;
        end
    end

    always_comb
    begin
        dec_out = '0;
        if (do_error)
        begin
            dec_out.count      = 2'd1;
            dec_out.res0.error = 1'b1;
            dec_out.res0.last  = 1'b1;
        end
        else if (do_emit)
        begin
            if (mode_utf16 && (emit_cp > BMP_MAX))
            begin
                dec_out.count     = 2'd2;
                dec_out.res0.unit = HI_SURR_BASE + {{(UNIT_W-10){1'b0}}, supp_off[19:10]};
                dec_out.res1.unit = LO_SURR_BASE + {{(UNIT_W-10){1'b0}}, supp_off[9:0]};
                dec_out.res1.last = 1'b1;
            end
            else
            begin
                dec_out.count     = 2'd1;
                dec_out.res0.unit = emit_cp;
                dec_out.res0.last = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/u8u16_resq.sv =====
// ----------------------------------------------------------------------------
// u8u16_resq
// Result queue: takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module u8u16_resq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  u8u16_pkg::dec_out_t    push,
    input  logic                   pop,
    output u8u16_pkg::result_t     head,
    output logic                   head_valid,
    output u8u16_pkg::res_status_t status
);
    import u8u16_pkg::*;

    result_t                entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_next;
    logic [RES_LVL_W-1:0]   level_reg;
    logic [RES_LVL_W-1:0]   level_next;
    logic                   do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);

    // Room for the worst case of two results, judged on the registered level.
    assign status.level    = level_reg;
    assign status.has_room = (level_reg <= RES_LVL_W'(RES_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + RES_PTR_W'(do_pop);
    assign level_next  = level_reg + RES_LVL_W'(push.count) - RES_LVL_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== tb/tb_utf8_to_utf16_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder
// Self-checking testbench of the validating UTF-8 decoder.
// ----------------------------------------------------------------------------
// UTF-8 strings go into the byte stream and every code unit that comes out is
// checked against a predictor of the decoder that runs on each accepted byte.
// Directed strings cover the shortest and longest form of every sequence
// length and each kind of malformed input. Random strings follow, mostly
// well formed with random code points, the rest noise, cut-off sequences,
// overlong forms, surrogates and values out of range. Both output modes are
// used, with random gaps on the input side, random stalls on the output side
// and one long output stall that backs the decoder up into its input.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder;

    import u8u16_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_SHOWN      = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_value
    logic        s_axis_tlast;     // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [20:0] code_unit, [23:21] zero
    logic        m_axis_tuser;     // error
    logic        m_axis_tlast;     // last_unit

    // Predictor state of the decoder.
    logic              utf16_out;
    logic [UNIT_W-1:0] cp_bits;
    logic [1:0]        cont_left;
    logic [2:0]        seq_len;
    logic              in_error;

    result_t     pending_units[$];
    logic [7:0]  str_bytes[$];
    int unsigned fail_count;
    logic        src_gaps;
    logic        sink_stalls;
    logic        hold_req;

    utf8_to_utf16_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void push_unit(input logic [UNIT_W-1:0] unit, input logic err,
                                      input logic last);
        result_t r;
        r.unit  = unit;
        r.error = err;
        r.last  = last;
        pending_units.insert(pending_units.size(), r);
    endfunction

    function automatic void clear_sequence();
        cp_bits   = '0;
        cont_left = 2'd0;
        seq_len   = SEQ_LEN_NONE;
    endfunction

    // An error on the final byte leaves the decoder ready for the next string.
    function automatic void push_error_unit(input logic eos);
        clear_sequence();
        in_error = ~eos;
        push_unit('0, 1'b1, 1'b1);
    endfunction

    function automatic void emit_code_point(input logic [UNIT_W-1:0] cp);
        logic [UNIT_W-1:0] v;
        if (utf16_out && cp > BMP_MAX)
        begin
            v = cp - SUPP_BASE;
            push_unit(HI_SURR_BASE + (v >> 10), 1'b0, 1'b0);
            push_unit(LO_SURR_BASE + (v & 21'h3FF), 1'b0, 1'b1);
        end
        else
            push_unit(cp, 1'b0, 1'b1);
    endfunction

    function automatic void predict_units(input logic [7:0] b, input logic eos);
        logic [UNIT_W-1:0] cp;
        logic              bad;
        if (in_error)
        begin
            if (eos)
            begin
                in_error = 1'b0;
                clear_sequence();
            end
            return;
        end
        if (cont_left == 2'd0)
        begin
            if (!b[7])
            begin
                emit_code_point({13'd0, b});
                return;
            end
            if (b[7:5] == 3'b110)
            begin
                cp_bits = {16'd0, b[4:0]};
                seq_len = SEQ_LEN_2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_bits = {17'd0, b[3:0]};
                seq_len = SEQ_LEN_3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_bits = {18'd0, b[2:0]};
                seq_len = SEQ_LEN_4;
            end
            else
            begin
                push_error_unit(eos);
                return;
            end
            cont_left = 2'(seq_len - 3'd1);
            if (eos)
                push_error_unit(eos);
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            push_error_unit(eos);
            return;
        end
        cp_bits   = {cp_bits[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0)
        begin
            if (eos)
                push_error_unit(eos);
            return;
        end
        cp  = cp_bits;
        bad = (seq_len == SEQ_LEN_2 && cp < MIN_CP_2) ||
              (seq_len == SEQ_LEN_3 && cp < MIN_CP_3) ||
              (seq_len == SEQ_LEN_4 && cp < MIN_CP_4) ||
              (cp >= SURR_LO && cp <= SURR_HI) || cp > MAX_CP;
        if (bad)
            push_error_unit(eos);
        else
        begin
            clear_sequence();
            emit_code_point(cp);
        end
    endfunction

    // ------------------------------------------------------------------------
    // String generation
    // ------------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // Encodes cp in exactly nb bytes, so a short value gives an overlong form.
    function automatic void append_seq(input logic [UNIT_W-1:0] cp, input int unsigned nb);
        case (nb)
            1:
                add_byte({1'b0, cp[6:0]});
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [UNIT_W-1:0] rand_cp(input int unsigned nb);
        logic [UNIT_W-1:0] cp;
        case (nb)
            1:       cp = UNIT_W'($urandom_range(0, 'h7F));
            2:       cp = UNIT_W'($urandom_range('h80, 'h7FF));
            3:       cp = UNIT_W'($urandom_range('h800, 'hFFFF));
            default: cp = UNIT_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        // Move surrogates up into the range F800 to FFFF, out of the surrogate range.
        if (cp >= SURR_LO && cp <= SURR_HI)
            cp = cp ^ 21'h002000;
        return cp;
    endfunction

    function automatic void append_flaw();
        logic [7:0]        b;
        int unsigned       nb;
        logic [UNIT_W-1:0] cp;
        case ($urandom_range(0, 3))
            0:
            begin
                nb = $urandom_range(2, 4);
                cp = (nb == 2) ? UNIT_W'($urandom_range(0, 'h7F)) :
                     (nb == 3) ? UNIT_W'($urandom_range(0, 'h7FF)) :
                                 UNIT_W'($urandom_range(0, 'hFFFF));
                append_seq(cp, nb);
            end
            1:
                append_seq(UNIT_W'($urandom_range('hD800, 'hDFFF)), 3);
            2:
                append_seq(UNIT_W'($urandom_range('h110000, 'h1FFFFF)), 4);
            default:
            begin
                nb = $urandom_range(2, 4);
                append_seq(rand_cp(nb), nb);
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                str_bytes[str_bytes.size() - $urandom_range(1, nb - 1)] = b;
            end
        endcase
    endfunction

    // Mostly well-formed strings; the rest are noise, a cut-off final sequence
    // or one malformed sequence somewhere in the string.
    function automatic void build_random_string();
        int unsigned kind;
        int unsigned n_cp;
        int unsigned flaw_at;
        int unsigned nb;
        int unsigned i;
        str_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            n_cp = $urandom_range(1, 6);
            for (i = 0; i < n_cp; i++)
                add_byte(8'($urandom));
            return;
        end
        n_cp    = $urandom_range(1, 8);
        flaw_at = (kind == 9) ? $urandom_range(0, n_cp - 1) : n_cp;
        for (i = 0; i < n_cp; i++)
        begin
            if (i == flaw_at)
                append_flaw();
            else
            begin
                nb = $urandom_range(1, 4);
                append_seq(rand_cp(nb), nb);
            end
        end
        if (kind == 8)
        begin
            nb = $urandom_range(2, 4);
            append_seq(rand_cp(nb), nb);
            repeat ($urandom_range(1, nb - 1))
                void'(str_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Returns right after the transaction with tvalid still high, so that the
    // next byte can follow in the next cycle.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge clk); while (!s_axis_tready);
        predict_units(b, eos);
    endtask

    task automatic send_string();
        int unsigned k;
        for (k = 0; k < str_bytes.size(); k++)
            send_byte(str_bytes[k], k == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    // A byte that ends a sequence may still be in flight when the last
    // expected unit has arrived, so a settling wait follows before going idle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        utf16_out = mode;
    endtask

    initial
    begin : sink
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_units
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.unit  = m_axis_tdata[UNIT_W-1:0];
            got.error = m_axis_tuser;
            got.last  = m_axis_tlast;
            if (pending_units.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: unexpected unit: tdata %h err %b last %b",
                             $realtime, m_axis_tdata, got.error, got.last);
            end
            else
            begin
                want = pending_units.pop_front();
                if (got !== want || m_axis_tdata[23:UNIT_W] !== 3'd0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 $realtime, want.unit, want.error, want.last,
                                 m_axis_tdata, got.error, got.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Shortest form of every sequence length, in UTF-16 mode.
    task automatic test_minimum_forms();
        write_mode(1'b1);
        str_bytes = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                      8'hF0, 8'h90, 8'h80, 8'h80};
        send_string();
        drain_pipeline();
    endtask

    task automatic test_malformed();
        str_bytes = '{8'h80};                          // stray continuation, final byte
        send_string();
        str_bytes = '{8'hFF, 8'h41};                   // bad lead, rest of string dropped
        send_string();
        str_bytes = '{8'hC0, 8'h80};                   // overlong two-byte form
        send_string();
        str_bytes = '{8'hED, 8'hA0, 8'h80};            // surrogate
        send_string();
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};     // above the last code point
        send_string();
        str_bytes = '{8'hC2, 8'h41};                   // bad continuation on final byte
        send_string();
        str_bytes = '{8'hE1};                          // lead byte ends the string
        send_string();
        str_bytes = '{8'hF0, 8'h90};                   // cut off mid-sequence
        send_string();
        drain_pipeline();
    endtask

    // Longest form of every sequence length, as UTF-32 code points.
    task automatic test_utf32_mode();
        write_mode(1'b0);
        str_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        drain_pipeline();
        write_mode(1'b1);
    endtask

    // Surrogate pairs pile up behind a long output stall until the input
    // side is stalled too.
    task automatic test_output_backpressure();
        src_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (10)
            append_seq(rand_cp(4), 4);
        send_string();
        drain_pipeline();
    endtask

    task automatic test_random_traffic(input logic mode, input int unsigned n_bytes,
                                       input logic gaps);
        int unsigned sent;
        write_mode(mode);
        sent = 0;
        while (sent < n_bytes)
        begin
            src_gaps = gaps && ($urandom_range(0, 3) != 0);
            build_random_string();
            sent += str_bytes.size();
            send_string();
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        fail_count  = 0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        hold_req    = 1'b0;
        utf16_out   = 1'b1;
        in_error    = 1'b0;
        clear_sequence();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_minimum_forms();
        test_malformed();
        test_utf32_mode();
        test_output_backpressure();
        test_random_traffic(1'b1, 500, 1'b1);
        test_random_traffic(1'b0, 600, 1'b1);
        test_random_traffic(1'b1, 400, 1'b1);
        sink_stalls = 1'b0;
        test_random_traffic(1'b0, 300, 1'b0);

        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_units.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
